/* rtl/kgsr_pkg.sv */
// kgsr_pkg: shared types and constants for the k-group stream reverser.
// Used by the top level, kgsr_front and kgsr_back; depends on nothing.
`timescale 1ns / 1ps

package kgsr_pkg;

    localparam int DATA_WIDTH     = 32;
    localparam int MAX_GROUP_DEF  = 16;
    localparam int MAX_GROUP_CAP  = 64;
    localparam int GS_W           = 5;
    localparam int CNT_W          = $clog2(MAX_GROUP_CAP + 1);
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    localparam logic [GS_W-1:0]   GS_RESET        = GS_W'(2);
    localparam logic [APB_AW-1:0] ADDR_GROUP_SIZE = APB_AW'(0);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         end_of_sequence;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value_out;
        logic                         last_of_burst;
        logic                         end_of_sequence_out;
    } t_out_item;

    // One finished group handed from the front to the back.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             reverse;
        logic             eos;
    } t_burst;

    // Back tells the front that a bank has been fully read.
    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

/* rtl/k_group_stream_reverser_top.sv */
// k_group_stream_reverser_top: top level with the group size register.
// Instantiates kgsr_front, kgsr_fifo, kgsr_ram and kgsr_back; uses kgsr_pkg.
`timescale 1ns / 1ps

// Values are written into one of two group banks as they arrive; a finished
// group (group size reached, or end flag) is handed to the read-out side,
// which plays it back reversed, or in order for a short tail at the end of a
// sequence. Input is taken at one request per cycle while a bank is free, and
// results leave at one per cycle while pop is held. A bank is freed only as
// its last value is read, and the input stalls while both banks still wait
// to be read out. A value reaches the output through the request queue, the
// read-out state, the RAM read and the result buffer. Group size is register
// 0 at byte address 0, reset value 2.

module k_group_stream_reverser_top #(
    parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    input  kgsr_pkg::t_in_item          i_data,
    output logic                        full,
    input  logic                        pop,
    output kgsr_pkg::t_out_item         o_data,
    output logic                        empty,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kgsr_pkg::APB_AW-1:0] paddr,
    input  logic [kgsr_pkg::APB_DW-1:0] pwdata,
    output logic [kgsr_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    import kgsr_pkg::*;

    localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    logic [GS_W-1:0]       r_group_size;
    logic                  we;
    logic [IW:0]           waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IW:0]           raddr;
    logic [DATA_WIDTH-1:0] rdata;
    logic                  desc_push;
    t_burst                desc_in;
    logic [$bits(t_burst)-1:0] desc_bits;
    t_burst                desc_out;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;
    t_release              release_info;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_GROUP_SIZE) ? APB_DW'(r_group_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= GS_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr == ADDR_GROUP_SIZE)) begin
            r_group_size <= pwdata[GS_W-1:0];
        end
    end

    kgsr_front #(.MAX_GROUP(MAX_GROUP), .IW(IW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data       (i_data),
        .o_full       (full),
        .i_group_size (r_group_size),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_desc_push  (desc_push),
        .o_desc       (desc_in),
        .i_q_full     (q_full),
        .i_release    (release_info)
    );

    kgsr_fifo #(.WIDTH($bits(t_burst)), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (desc_push),
        .i_wdata (desc_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rdata (desc_bits),
        .o_empty (q_empty)
    );

    assign desc_out = t_burst'(desc_bits);

    kgsr_ram #(.WIDTH(DATA_WIDTH), .DEPTH(2 ** (IW + 1)), .AW(IW + 1)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    kgsr_back #(.MAX_GROUP(MAX_GROUP), .IW(IW)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_desc    (desc_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_re      (re),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .o_release (release_info),
        .o_data    (o_data),
        .o_empty   (empty),
        .i_pop     (pop)
    );

endmodule

/* rtl/kgsr_ram.sv */
// kgsr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module kgsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/kgsr_fifo.sv */
// kgsr_fifo: small register FIFO carrying burst requests from front to back.
// No dependencies; DEPTH must be a power of two.
`timescale 1ns / 1ps

module kgsr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [PW:0]      r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == (PW + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_mem[r_wp] <= i_wdata;
                r_wp        <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/kgsr_front.sv */
// kgsr_front: accepts input requests, fills the ping-pong group buffer and
// issues one burst request per finished group. Depends on kgsr_pkg.
`timescale 1ns / 1ps

module kgsr_front #(
    parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF,
    parameter int IW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  kgsr_pkg::t_in_item              i_data,
    output logic                            o_full,
    input  logic [kgsr_pkg::GS_W-1:0]       i_group_size,
    output logic                            o_we,
    output logic [IW:0]                     o_waddr,
    output logic [kgsr_pkg::DATA_WIDTH-1:0] o_wdata,
    output logic                            o_desc_push,
    output kgsr_pkg::t_burst                o_desc,
    input  logic                            i_q_full,
    input  kgsr_pkg::t_release              i_release
);

    import kgsr_pkg::*;

    localparam int FW = $clog2(MAX_GROUP + 1);

    logic          r_wbank;
    logic [1:0]    r_busy;
    logic [1:0]    n_busy;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] k_eff;
    logic [FW-1:0] n;
    logic          accept;
    logic          reach;
    logic          done;

    always_comb begin
        if (i_group_size == '0) begin
            k_eff = FW'(1);
        end else if (int'(i_group_size) > MAX_GROUP) begin
            k_eff = FW'(MAX_GROUP);
        end else begin
            k_eff = FW'(i_group_size);
        end
    end

    assign o_full  = r_busy[r_wbank] || i_q_full;
    assign accept  = i_push && !o_full;
    assign n       = r_fill + 1'b1;
    assign reach   = (n >= k_eff);
    assign done    = reach || i_data.end_of_sequence;

    assign o_we    = accept;
    assign o_waddr = {r_wbank, IW'(r_fill)};
    assign o_wdata = i_data.value;

    assign o_desc_push    = accept && done;
    assign o_desc.bank    = r_wbank;
    assign o_desc.count   = CNT_W'(n);
    assign o_desc.reverse = reach;
    assign o_desc.eos     = i_data.end_of_sequence;

    always_comb begin
        n_busy = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end
        if (accept && done) begin
            n_busy[r_wbank] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wbank <= 1'b0;
            r_busy  <= '0;
            r_fill  <= '0;
        end else begin
            r_busy <= n_busy;
            if (accept) begin
                if (done) begin
                    r_fill  <= '0;
                    r_wbank <= ~r_wbank;
                end else begin
                    r_fill <= n;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_fill) < MAX_GROUP)
        else $error("group fill count reached buffer depth");

    a_bank_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_desc_push |=> r_busy[$past(r_wbank)] && (r_wbank != $past(r_wbank)))
        else $error("finished bank not handed to back");
`endif

endmodule

/* rtl/kgsr_back.sv */
// kgsr_back: reads finished groups out of the group buffer in forward or
// reverse order and queues the results. Depends on kgsr_pkg.
`timescale 1ns / 1ps

module kgsr_back #(
    parameter int MAX_GROUP = kgsr_pkg::MAX_GROUP_DEF,
    parameter int IW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kgsr_pkg::t_burst                i_desc,
    input  logic                            i_q_empty,
    output logic                            o_q_pop,
    output logic                            o_re,
    output logic [IW:0]                     o_raddr,
    input  logic [kgsr_pkg::DATA_WIDTH-1:0] i_rdata,
    output kgsr_pkg::t_release              o_release,
    output kgsr_pkg::t_out_item             o_data,
    output logic                            o_empty,
    input  logic                            i_pop
);

    import kgsr_pkg::*;

    localparam int FW = $clog2(MAX_GROUP + 1);

    logic          r_act;
    logic          r_bank;
    logic          r_rev;
    logic          r_eos;
    logic [FW-1:0] r_n;
    logic [FW-1:0] r_i;
    logic          r_pend;
    logic          r_pend_last;
    logic          r_pend_eos;
    t_out_item     r_obuf [2];
    logic          r_orp;
    logic          r_owp;
    logic [1:0]    r_ocnt;

    logic          pop_fire;
    logic [1:0]    used;
    logic          issue;
    logic          issue_last;
    logic          load;
    logic [FW-1:0] idx;

    assign pop_fire   = i_pop && (r_ocnt != 2'd0);
    assign used       = r_ocnt + {1'b0, r_pend};
    assign issue      = r_act && (pop_fire ? (used < 2'd3) : (used < 2'd2));
    assign issue_last = issue && (r_i == r_n - 1'b1);
    assign load       = !i_q_empty && (!r_act || issue_last);
    assign idx        = r_rev ? (r_n - r_i - 1'b1) : r_i;

    assign o_q_pop         = load;
    assign o_re            = issue;
    assign o_raddr         = {r_bank, IW'(idx)};
    assign o_release.valid = issue_last;
    assign o_release.bank  = r_bank;
    assign o_empty         = (r_ocnt == 2'd0);
    assign o_data          = r_obuf[r_orp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_pend <= 1'b0;
            r_orp  <= 1'b0;
            r_owp  <= 1'b0;
            r_ocnt <= '0;
        end else begin
            if (load) begin
                r_act  <= 1'b1;
                r_bank <= i_desc.bank;
                r_n    <= FW'(i_desc.count);
                r_i    <= '0;
                r_rev  <= i_desc.reverse;
                r_eos  <= i_desc.eos;
            end else if (issue_last) begin
                r_act <= 1'b0;
            end else if (issue) begin
                r_i <= r_i + 1'b1;
            end
            r_pend      <= issue;
            r_pend_last <= issue_last;
            r_pend_eos  <= issue_last && r_eos;
            if (r_pend) begin
                r_obuf[r_owp] <= '{value_out: i_rdata, last_of_burst: r_pend_last,
                                   end_of_sequence_out: r_pend_eos};
                r_owp         <= ~r_owp;
            end
            if (pop_fire) begin
                r_orp <= ~r_orp;
            end
            case ({r_pend, pop_fire})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && !pop_fire |-> r_ocnt != 2'd2)
        else $error("result buffer overflow");

    a_bank_alternates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_release.valid |=> !r_act || (r_bank != $past(r_bank)))
        else $error("back reloaded the bank it just released");
`endif

endmodule
